// ----- src/spf_pkg.sv -----
// Shared types and constants for the smallest-prime-factor factorizer.
`timescale 1ns / 1ps
package spf_pkg;

  localparam int unsigned VALUE_BITS_DEF = 16;

  typedef enum logic [2:0] {
    ST_FACTOR    = 3'd0,
    ST_NONE      = 3'd1,
    ST_OVER      = 3'd2,
    ST_NOT_BUILT = 3'd3,
    ST_BUILT     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_SQ, S_CHK, S_TESTI, S_RDJ, S_WJ,
    S_RD, S_PICK, S_DIV, S_NEXT, S_LAST, S_ONE
  } state_t;

endpackage

// ----- src/spf_if.sv -----
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface spf_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] value;
  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface spf_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] prime;
  logic [4:0]  exponent;
  logic        last;
  logic [2:0]  status;
  modport source (output valid, output prime, output exponent, output last,
                  output status, input ready);
  modport sink   (input valid, input prime, input exponent, input last,
                  input status, output ready);
endinterface

// ----- src/smallest_prime_factor_factorizer.sv -----
// Top level: smallest-prime-factor table, sieve builder and factorizer.
`timescale 1ns / 1ps
// Usage
//   req: one beat carries mode and value. mode 0 builds the table up to
//   table_limit, mode 1 factors value. req.ready is high only while idle.
//   rsp: one beat per result. A build gives one "built" beat. A factor item
//   gives one beat per distinct prime, ascending, with last on the final one;
//   values 0 and 1, values over the limit and an unbuilt table give a single
//   status beat with last set.
//   cfg_we/cfg_wdata write table_limit (low VALUE_BITS bits used); a write
//   marks the table unbuilt.
// Sequence
//   Build: a fill pass writes every entry 0..limit with its own index, then
//   per sieve base i (i*i <= limit) entry i is read and, for primes, each
//   multiple from i*i on is read and rewritten if it still holds itself.
//   The table memory has one write port and one registered read port.
//   Factor: per prime factor (with multiplicity) one table read, a restoring
//   divide of VALUE_BITS quotient bits and one check step.
// Reset clears the sequencer, the output valid flag and the built flag, and
// sets table_limit to all ones; table contents are not cleared. A stalled
// rsp holds the current beat; the sequencer waits only when it has the
// next beat ready.
module smallest_prime_factor_factorizer #(
  parameter int unsigned VALUE_BITS = spf_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  spf_req_if.sink     req,
  spf_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import spf_pkg::*;

  localparam int unsigned VB    = VALUE_BITS;
  localparam int unsigned EW    = (VB > 16) ? VB : 16;
  localparam int unsigned CW    = $clog2(VB);
  localparam int unsigned DEPTH = 1 << VB;

  state_t state, state_next;

  logic [15:0]     lim;
  logic            table_ready;
  logic [VB-1:0]   mem [DEPTH];
  logic [VB-1:0]   rdata;
  logic [VB-1:0]   raddr;
  logic            we;
  logic [VB-1:0]   waddr;
  logic [VB-1:0]   wdata;

  logic [VB-1:0]   i;
  logic [VB:0]     j;
  logic [2*VB-1:0] sq;
  logic [VB-1:0]   n;
  logic [VB-1:0]   cur_p;
  logic [4:0]      cur_e;
  logic [VB-1:0]   rem;
  logic [VB-1:0]   qw;
  logic [CW-1:0]   cnt;
  status_t         one_status;

  logic            out_valid;
  logic [15:0]     out_prime;
  logic [4:0]      out_exp;
  logic            out_last;
  status_t         out_status;

  logic [VB-1:0]   limv;
  logic [VB-1:0]   req_v;
  logic [EW-1:0]   lim_ext, val_ext, p_ext;
  logic            out_free;
  logic            ld;
  logic [15:0]     ld_prime;
  logic [4:0]      ld_exp;
  logic            ld_last;
  status_t         ld_status;
  logic            new_prime;
  logic [VB:0]     j_step;
  logic [VB:0]     div_t;
  logic            div_ge;
  logic [VB-1:0]   rem_next;
  logic [VB-1:0]   qw_next;

  assign lim_ext = EW'(lim);
  assign val_ext = EW'(req.value);
  assign p_ext   = EW'(cur_p);
  assign limv    = lim_ext[VB-1:0];
  assign req_v   = val_ext[VB-1:0];
  assign out_free = !out_valid || rsp.ready;
  assign new_prime = !(cur_e != 5'd0 && rdata == cur_p);
  assign j_step  = j + (VB+1)'(i);

  // restoring divide step, one quotient bit a cycle
  assign div_t    = {rem, qw[VB-1]};
  assign div_ge   = div_t >= (VB+1)'(cur_p);
  assign rem_next = div_ge ? VB'(div_t - (VB+1)'(cur_p)) : div_t[VB-1:0];
  assign qw_next  = {qw[VB-2:0], div_ge};

  assign req.ready = (state == S_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.prime    = out_prime;
  assign rsp.exponent = out_exp;
  assign rsp.last     = out_last;
  assign rsp.status   = out_status;

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    raddr = n;
    we    = 1'b0;
    waddr = i;
    wdata = i;
    ld        = 1'b0;
    ld_prime  = p_ext[15:0];
    ld_exp    = cur_e;
    ld_last   = 1'b0;
    ld_status = ST_FACTOR;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (!req.mode) begin
            state_next = S_FILL;
          end else if (req_v <= VB'(1) || !table_ready || req_v > limv) begin
            state_next = S_ONE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_FILL: begin
        we = 1'b1;
        if (i == limv) begin
          state_next = S_SQ;
        end
      end
      S_SQ: state_next = S_CHK;
      S_CHK: begin
        raddr = i;
        state_next = (sq > (2*VB)'(limv)) ? S_ONE : S_TESTI;
      end
      S_TESTI: state_next = (rdata == i) ? S_RDJ : S_SQ;
      S_RDJ: begin
        raddr = j[VB-1:0];
        state_next = S_WJ;
      end
      S_WJ: begin
        waddr = j[VB-1:0];
        we = (rdata == j[VB-1:0]);
        state_next = (j_step > (VB+1)'(limv)) ? S_SQ : S_RDJ;
      end
      S_RD: state_next = S_PICK;
      S_PICK: begin
        if (new_prime && cur_e != 5'd0) begin
          ld = out_free;
          if (out_free) begin
            state_next = S_DIV;
          end
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt == CW'(0)) begin
          state_next = S_NEXT;
        end
      end
      S_NEXT: state_next = (n > VB'(1)) ? S_RD : S_LAST;
      S_LAST: begin
        ld = out_free;
        ld_last = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_ONE: begin
        ld = out_free;
        ld_prime = 16'd0;
        ld_exp = 5'd0;
        ld_last = 1'b1;
        ld_status = one_status;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lim         <= 16'hFFFF;
      table_ready <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        lim         <= cfg_wdata;
        table_ready <= 1'b0;
      end else if (state == S_CHK && sq > (2*VB)'(limv)) begin
        table_ready <= 1'b1;
      end
      if (ld) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ld) begin
      out_prime  <= ld_prime;
      out_exp    <= ld_exp;
      out_last   <= ld_last;
      out_status <= ld_status;
    end
    case (state)
      S_IDLE: begin
        i     <= '0;
        cur_e <= 5'd0;
        n     <= req_v;
        if (req_v <= VB'(1)) begin
          one_status <= ST_NONE;
        end else if (!table_ready) begin
          one_status <= ST_NOT_BUILT;
        end else begin
          one_status <= ST_OVER;
        end
      end
      S_FILL: begin
        i <= (i == limv) ? VB'(2) : i + VB'(1);
      end
      S_SQ: sq <= (2*VB)'(i) * (2*VB)'(i);
      S_CHK: one_status <= ST_BUILT;
      S_TESTI: begin
        if (rdata == i) begin
          j <= sq[VB:0];
        end else begin
          i <= i + VB'(1);
        end
      end
      S_WJ: begin
        if (j_step > (VB+1)'(limv)) begin
          i <= i + VB'(1);
        end else begin
          j <= j_step;
        end
      end
      S_PICK: begin
        rem <= '0;
        qw  <= n;
        cnt <= CW'(VB-1);
        if (!new_prime) begin
          cur_e <= cur_e + 5'd1;
        end else if (cur_e == 5'd0 || out_free) begin
          cur_p <= rdata;
          cur_e <= 5'd1;
        end
      end
      S_DIV: begin
        rem <= rem_next;
        qw  <= qw_next;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(0)) begin
          n <= qw_next;
        end
      end
      default: ;
    endcase
  end

  // every table entry divides the value it is read for
  a_exact_div: assert property (@(posedge clk) disable iff (rst)
    state == S_NEXT |-> rem == '0)
    else $error("inexact divide by table entry");

  a_factor_exp: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_FACTOR |-> rsp.exponent != 5'd0)
    else $error("factor beat with zero exponent");

  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(table_ready) |-> $past(cfg_we))
    else $error("table marked unbuilt without a limit write");

  a_built_beat: assert property (@(posedge clk) disable iff (rst)
    $rose(table_ready) |-> state == S_ONE && one_status == ST_BUILT)
    else $error("table built outside the sieve end");

endmodule
